[src/m4tu_pkg.sv]
// package for the 4x4 matrix transform unit
// holds payload structs, mode codes, widths and fixed-point helpers; no dependencies
package m4tu_pkg;

   localparam int ELEMENT_WIDTH = 32;
   localparam int FRAC_BITS     = 16;
   localparam int PROD_WIDTH    = 2 * ELEMENT_WIDTH;
   localparam int ACC_WIDTH     = PROD_WIDTH + 2;
   localparam int QUEUE_DEPTH   = 2;

   typedef enum logic [2:0] {
      MODE_WRITE     = 3'd0,
      MODE_CLEAR     = 3'd1,
      MODE_IDENTITY  = 3'd2,
      MODE_TRANSPOSE = 3'd3,
      MODE_MULTIPLY  = 3'd4,
      MODE_READ      = 3'd5
   } mode_type;

   typedef struct packed {
      logic [2:0]         mode;
      logic [3:0]         elem_index;
      logic signed [31:0] elem_value;
   } req_type;

   typedef struct packed {
      logic [3:0]         read_index;
      logic signed [31:0] read_value;
   } rsp_type;

   // command handed from front to back
   typedef struct packed {
      mode_type                  op;
      logic [3:0]                index;
      logic [ELEMENT_WIDTH-1:0]  value;
   } cmd_type;

   localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_MAX =
      {1'b0, {(ELEMENT_WIDTH-1){1'b1}}};
   localparam logic signed [ELEMENT_WIDTH-1:0] ELEM_MIN =
      {1'b1, {(ELEMENT_WIDTH-1){1'b0}}};

   // identity one, clipped to the largest element value
   localparam logic [ELEMENT_WIDTH-1:0] ELEM_ONE =
      (FRAC_BITS >= ELEMENT_WIDTH - 1) ? ELEM_MAX :
      ELEMENT_WIDTH'(64'd1 << FRAC_BITS);

   // shift a sum right and saturate to element width
   function automatic logic [ELEMENT_WIDTH-1:0] finish_sum(
      input logic signed [ACC_WIDTH-1:0] acc);
      logic signed [ACC_WIDTH-1:0] sh;
      sh = acc >>> FRAC_BITS;
      if (sh > ACC_WIDTH'(ELEM_MAX))      finish_sum = ELEM_MAX;
      else if (sh < ACC_WIDTH'(ELEM_MIN)) finish_sum = ELEM_MIN;
      else                                finish_sum = sh[ELEMENT_WIDTH-1:0];
   endfunction

endpackage

[src/m4tu_front.sv]
// front part: accepts items, drops unused modes, queues commands for the back part
// depends on m4tu_pkg
module m4tu_front import m4tu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    full,
   input  logic    cmd_pop,
   output logic    cmd_valid,
   output cmd_type cmd_data
);

   cmd_type    queue_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       accept, useful, put, take;
   cmd_type    cmd_new;

   // classify the item
   always_comb begin
      useful = (req_data.mode <= MODE_READ);
      cmd_new.op    = mode_type'(req_data.mode);
      cmd_new.index = req_data.elem_index;
      cmd_new.value = ELEMENT_WIDTH'(req_data.elem_value);
   end

   assign full      = (count_ff == 2'(QUEUE_DEPTH));
   assign accept    = req_push && !full;
   assign put       = accept && useful;
   assign cmd_valid = (count_ff != 2'd0);
   assign take      = cmd_pop && cmd_valid;
   assign cmd_data  = queue_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = put  ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = take ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(put) - 2'(take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (put) queue_ff[wr_ptr_ff] <= cmd_new;
   end

endmodule

[src/m4tu_back.sv]
// back part: holds both matrices and carries out commands; one mac, one product per cycle
// depends on m4tu_pkg
module m4tu_back import m4tu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   input  cmd_type cmd_data,
   output logic    cmd_pop,
   output logic    rsp_empty,
   output rsp_type rsp_data,
   input  logic    rsp_pop
);

   typedef enum logic [1:0] {ST_IDLE, ST_MUL, ST_WAIT, ST_COPY} state_type;

   logic [ELEMENT_WIDTH-1:0] cur_ff [16];
   logic [ELEMENT_WIDTH-1:0] opd_ff [16];
   logic [ELEMENT_WIDTH-1:0] tmp_ff [16];
   state_type                state_ff;
   logic [5:0]               step_ff;
   logic signed [ACC_WIDTH-1:0]  acc_ff;
   logic signed [PROD_WIDTH-1:0] prod_ff;
   logic                     prod_vld_ff;
   logic [5:0]               prod_step_ff;
   logic                     rsp_full_ff;
   rsp_type                  rsp_ff;
   logic [1:0]               k, r, c, pk, pr, pc;
   logic signed [ACC_WIDTH-1:0] acc_in;

   assign k  = step_ff[1:0];
   assign r  = step_ff[3:2];
   assign c  = step_ff[5:4];
   assign pk = prod_step_ff[1:0];
   assign pr = prod_step_ff[3:2];
   assign pc = prod_step_ff[5:4];

   assign cmd_pop   = (state_ff == ST_IDLE) && cmd_valid &&
                      !(cmd_data.op == MODE_READ && rsp_full_ff);
   assign rsp_empty = !rsp_full_ff;
   assign rsp_data  = rsp_ff;

   // accumulate, restarting at the first product of each element
   assign acc_in = ((pk == 2'd0) ? ACC_WIDTH'(0) : acc_ff) + ACC_WIDTH'(prod_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         step_ff     <= 6'd0;
         prod_vld_ff <= 1'b0;
         rsp_full_ff <= 1'b0;
         for (int i = 0; i < 16; i++) begin
            cur_ff[i] <= (i % 5 == 0) ? ELEM_ONE : '0;
            opd_ff[i] <= '0;
         end
      end else begin
         if (rsp_pop && rsp_full_ff) rsp_full_ff <= 1'b0;
         // product stage, then accumulate stage
         prod_vld_ff <= (state_ff == ST_MUL);
         if (state_ff == ST_MUL) begin
            prod_ff      <= $signed(cur_ff[{k, r}]) * $signed(opd_ff[{c, k}]);
            prod_step_ff <= step_ff;
            step_ff      <= step_ff + 6'd1;
            if (step_ff == 6'd63) state_ff <= ST_WAIT;
         end
         if (prod_vld_ff) begin
            acc_ff <= acc_in;
            if (pk == 2'd3) tmp_ff[{pc, pr}] <= finish_sum(acc_in);
         end
         case (state_ff)
            ST_IDLE: begin
               if (cmd_pop) begin
                  case (cmd_data.op)
                     MODE_WRITE: opd_ff[cmd_data.index] <= cmd_data.value;
                     MODE_CLEAR: for (int i = 0; i < 16; i++) cur_ff[i] <= '0;
                     MODE_IDENTITY:
                        for (int i = 0; i < 16; i++)
                           cur_ff[i] <= (i % 5 == 0) ? ELEM_ONE : '0;
                     MODE_TRANSPOSE:
                        for (int i = 0; i < 16; i++)
                           cur_ff[i] <= cur_ff[(i % 4) * 4 + i / 4];
                     MODE_MULTIPLY: begin
                        state_ff <= ST_MUL;
                        step_ff  <= 6'd0;
                     end
                     MODE_READ: begin
                        rsp_full_ff        <= 1'b1;
                        rsp_ff.read_index  <= cmd_data.index;
                        rsp_ff.read_value  <= 32'($signed(cur_ff[cmd_data.index]));
                     end
                     default: ;
                  endcase
               end
            end
            ST_MUL: ;
            // drain the two-stage mac
            ST_WAIT: if (!prod_vld_ff) state_ff <= ST_COPY;
            ST_COPY: begin
               for (int i = 0; i < 16; i++) cur_ff[i] <= tmp_ff[i];
               state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

[src/mat4_transform_unit.sv]
// 4x4 matrix transform unit, top level; joins front queue and back executor
// depends on m4tu_pkg, m4tu_front, m4tu_back
// a read goes through the front queue and then the back result register; writes, clear,
// identity, transpose act when popped; a multiply runs 64 products on one mac and holds
// the back; throughput: one item per cycle unless full, a read once the last is popped
// reset: synchronous; current matrix to identity, operand to zero, queues empty
module mat4_transform_unit import m4tu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   output logic    full,
   output logic    empty,
   input  logic    pop,
   output rsp_type rsp_data
);

   logic    cmd_valid, cmd_pop;
   cmd_type cmd_data;

   m4tu_front u_front (
      .clock, .reset, .req_push, .req_data, .full,
      .cmd_pop, .cmd_valid, .cmd_data
   );

   m4tu_back u_back (
      .clock, .reset, .cmd_valid, .cmd_data, .cmd_pop,
      .rsp_empty(empty), .rsp_data, .rsp_pop(pop)
   );

endmodule

[src/m4tu_checker.sv]
// port checker for the matrix transform unit, bound to the top level
// depends on m4tu_pkg
module m4tu_checker import m4tu_pkg::*; (
   input logic    clock,
   input logic    reset,
   input logic    req_push,
   input req_type req_data,
   input logic    full,
   input logic    empty,
   input logic    pop,
   input rsp_type rsp_data
);

   // a result held and not taken stays
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> !empty) else $error("result dropped");

   // a waiting result does not change until taken
   a_stable: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> $stable(rsp_data)) else $error("result changed");

   // an accepted read is answered later
   a_read: assert property (@(posedge clock) disable iff (reset)
      (req_push && !full && req_data.mode == MODE_READ) |-> ##[2:$] !empty)
      else $error("read result missing");

   // after reset nothing is waiting
   a_rst: assert property (@(posedge clock) $past(reset) |-> empty && !full)
      else $error("reset state");

endmodule

bind mat4_transform_unit m4tu_checker u_checker (
   .clock, .reset, .req_push, .req_data, .full, .empty, .pop, .rsp_data
);

[sim/mat4_transform_unit_checker.sv]
`timescale 1ns / 100ps
// checker for the 4x4 matrix transform unit: watches both queue ports,
// predicts read results from its own copy of both matrices; uses m4tu_pkg
module mat4_transform_unit_checker import m4tu_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_push,
   input  req_type req_data,
   input  logic    full,
   input  logic    empty,
   input  logic    pop,
   input  rsp_type rsp_data,
   output int      error_count,
   output int      pending_reads,
   output int      read_count
);

   logic signed [31:0] cur_mat [16];
   logic signed [31:0] opd_mat [16];
   rsp_type            read_queue [$];

   // load the identity into the current matrix
   task automatic load_identity();
      for (int i = 0; i < 16; i++) cur_mat[i] = 32'sd0;
      for (int i = 0; i < 4; i++) cur_mat[i*4+i] = 32'sh0001_0000;
   endtask

   // current times operand, shifted and saturated
   task automatic multiply_current();
      logic signed [31:0] t [16];
      logic signed [65:0] acc;
      logic signed [65:0] sh;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            acc = '0;
            for (int k = 0; k < 4; k++) begin
               acc += 66'(cur_mat[k*4+r]) * 66'(opd_mat[c*4+k]);
            end
            sh = acc >>> 16;
            if (sh > 66'sd2147483647) t[c*4+r] = 32'sh7fff_ffff;
            else if (sh < -66'sd2147483648) t[c*4+r] = 32'sh8000_0000;
            else t[c*4+r] = sh[31:0];
         end
      end
      cur_mat = t;
   endtask

   // apply one accepted item to the matrices
   task automatic apply_item(input req_type item);
      logic signed [31:0] t [16];
      rsp_type            rd;
      case (item.mode)
         MODE_WRITE: begin
            opd_mat[item.elem_index] = item.elem_value;
         end
         MODE_CLEAR: begin
            for (int i = 0; i < 16; i++) cur_mat[i] = 32'sd0;
         end
         MODE_IDENTITY: begin
            load_identity();
         end
         MODE_TRANSPOSE: begin
            for (int c = 0; c < 4; c++)
               for (int r = 0; r < 4; r++) t[c*4+r] = cur_mat[r*4+c];
            cur_mat = t;
         end
         MODE_MULTIPLY: begin
            multiply_current();
         end
         MODE_READ: begin
            rd.read_index = item.elem_index;
            rd.read_value = cur_mat[item.elem_index];
            read_queue.push_back(rd);
         end
         default: begin
         end
      endcase
   endtask

   task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
      error_count++;
      $display("%0t: %s got %h expected %h", $time, what, got, want);
   endtask

   // watch both channels at each edge
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         load_identity();
         for (int i = 0; i < 16; i++) opd_mat[i] = 32'sd0;
         read_queue.delete();
      end else begin
         if (pop && !empty) begin
            read_count++;
            if (read_queue.size() == 0) begin
               report("unexpected read item, index", 32'(rsp_data.read_index), 32'd0);
            end else begin
               want = read_queue.pop_front();
               if (rsp_data.read_index !== want.read_index)
                  report("read_index", 32'(rsp_data.read_index), 32'(want.read_index));
               if (rsp_data.read_value !== want.read_value)
                  report("read_value", rsp_data.read_value, want.read_value);
            end
         end
         if (req_push && !full) apply_item(req_data);
      end
      pending_reads = read_queue.size();
   end

   initial begin
      error_count = 0;
      pending_reads = 0;
      read_count = 0;
   end

endmodule

[sim/mat4_transform_unit_test.sv]
`timescale 1ns / 100ps
// testbench top for the 4x4 matrix transform unit: drives items and pops
// depends on m4tu_pkg, mat4_transform_unit and mat4_transform_unit_checker
module mat4_transform_unit_test;
   import m4tu_pkg::*;

   localparam int RANDOM_ITEMS = 1820;
   localparam int STALL_LIMIT  = 20000;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_push = 1'b0;
   req_type req_data = '0;
   logic    full;
   logic    empty;
   logic    pop = 1'b0;
   rsp_type rsp_data;
   int      error_count;
   int      pending_reads;
   int      read_count;
   int      idle_cycles = 0;
   bit      sender_done = 1'b0;
   bit      quiet_tail = 1'b0;
   bit      hold_off = 1'b0;
   int      item_count = 0;

   mat4_transform_unit dut (
      .clock(clock), .reset(reset), .req_push(req_push), .req_data(req_data),
      .full(full), .empty(empty), .pop(pop), .rsp_data(rsp_data)
   );

   mat4_transform_unit_checker checker_inst (
      .clock(clock), .reset(reset), .req_push(req_push), .req_data(req_data),
      .full(full), .empty(empty), .pop(pop), .rsp_data(rsp_data),
      .error_count(error_count), .pending_reads(pending_reads),
      .read_count(read_count)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // offer one item and wait for it to be taken
   task automatic send_item(input mode_type m, input logic [3:0] idx, input logic [31:0] val);
      req_push <= 1'b1;
      req_data <= '{mode: m, elem_index: idx, elem_value: val};
      @(posedge clock);
      while (full) @(posedge clock);
      item_count++;
   endtask

   // random gap between items, dropped in the tail
   task automatic maybe_gap();
      if (!quiet_tail && $urandom_range(0, 3) == 0) begin
         req_push <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   function automatic logic [31:0] random_value();
      case ($urandom_range(0, 5))
         0: return 32'h7fff_ffff;
         1: return 32'h8000_0000;
         2: return 32'($urandom_range(0, 32'h3_0000)) - 32'h1_8000;
         3: return 32'h0001_0000;
         default: return $urandom;
      endcase
   endfunction

   // receiver: random stall bursts, one long hold-off on request
   initial begin
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_off) begin
            pop <= 1'b0;
            for (int i = 0; i < 300; i++) @(posedge clock);
            hold_off = 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 5) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         pop <= 1'b1;
      end
   end

   // watchdog on cycles with nothing accepted
   always @(posedge clock) begin
      if ((req_push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("watchdog: no progress");
         $display("mat4_transform_unit: mismatch");
         $finish;
      end
   end

   initial begin
      mode_type m;
      logic [31:0] v;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset values, extremes, every mode, unused modes
      send_item(MODE_READ, 4'd0, 32'hffff_ffff);
      send_item(MODE_READ, 4'd15, 32'd0);
      send_item(MODE_READ, 4'd1, 32'd0);
      send_item(MODE_MULTIPLY, 4'd7, 32'd5);
      send_item(MODE_READ, 4'd5, 32'd0);
      send_item(MODE_IDENTITY, 4'd0, 32'd0);
      for (int i = 0; i < 16; i++)
         send_item(MODE_WRITE, 4'(i), (i % 2) ? 32'h7fff_ffff : 32'h8000_0000);
      send_item(mode_type'(3'd6), 4'd3, 32'h1234_5678);
      send_item(mode_type'(3'd7), 4'd3, 32'h1234_5678);
      send_item(MODE_TRANSPOSE, 4'd0, 32'd0);
      send_item(MODE_MULTIPLY, 4'd0, 32'd0);
      send_item(MODE_READ, 4'd3, 32'd0);
      send_item(MODE_CLEAR, 4'hf, 32'hffff_ffff);
      send_item(MODE_READ, 4'd10, 32'd0);

      // random: mostly operand loads and reads, some multiplies and other modes
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS - 250) quiet_tail = 1'b1;
         if (n == 400) hold_off = 1'b1;
         if (n == 900) begin
            req_push <= 1'b0;
            while (pending_reads != 0) @(posedge clock);
         end
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: m = MODE_WRITE;
            7: m = MODE_CLEAR;
            8: m = MODE_IDENTITY;
            9: m = MODE_TRANSPOSE;
            10, 11: m = MODE_MULTIPLY;
            12: m = mode_type'(3'($urandom_range(6, 7)));
            default: m = MODE_READ;
         endcase
         v = random_value();
         send_item(m, 4'($urandom_range(0, 15)), v);
         maybe_gap();
      end
      req_push <= 1'b0;
      sender_done = 1'b1;

      // drain then let the block settle
      while (pending_reads != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      $display("sent %0d items covering all modes, %0d reads checked", item_count, read_count);
      if (error_count == 0) $display("mat4_transform_unit: match");
      else $display("mat4_transform_unit: mismatch");
      $finish;
   end

endmodule

[sim.f]
src/m4tu_pkg.sv
src/m4tu_front.sv
src/m4tu_back.sv
src/mat4_transform_unit.sv
src/m4tu_checker.sv
sim/mat4_transform_unit_checker.sv
sim/mat4_transform_unit_test.sv
